// ===== rtl/mcta_pkg.sv =====
// mcta_pkg: shared widths, codes, chain payload types and the row pitch function
// for the mip chain texel address core. No dependencies.
package mcta_pkg;

  localparam int NUM_CELLS = 16;   // one cell per possible mip level
  localparam int MIP_W     = 5;
  localparam int ROW_W     = 22;   // unsaturated row pitch
  localparam int TOT_W     = 38;   // unsaturated surface size
  localparam int ACC_W     = 39;   // layer size and mip prefix sums
  localparam int PIX_W     = 6;    // bytes per pixel, up to 32
  localparam int BASE_W    = 58;
  localparam int OFF_W     = 49;
  localparam int SROW_W    = 20;
  localparam int SIZE_W    = 36;

  localparam logic [2:0] REG_BASE_WIDTH  = 3'd0;
  localparam logic [2:0] REG_BASE_HEIGHT = 3'd1;
  localparam logic [2:0] REG_MIP_COUNT   = 3'd2;
  localparam logic [2:0] REG_LAYER_COUNT = 3'd3;
  localparam logic [2:0] REG_PLANE_COUNT = 3'd4;
  localparam logic [2:0] REG_ELEM_SIZE   = 3'd5;
  localparam logic [2:0] REG_BLOCK_COMP  = 3'd6;

  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_RANGE      = 2'd1;
  localparam logic [1:0] ST_COMPRESSED = 2'd2;

  typedef struct packed {
    logic [15:0]      w;
    logic [15:0]      h;
    logic [ROW_W-1:0] row;
    logic [ACC_W-1:0] layer_bytes;
    logic [ACC_W-1:0] prefix;
    logic [ROW_W-1:0] sel_row;
    logic [TOT_W-1:0] sel_total;
    logic [15:0]      sel_h;
  } chain_t;

  typedef struct packed {
    logic [MIP_W-1:0] mips;
    logic [3:0]       mip;
    logic [7:0]       es;
    logic             comp;
  } cell_ctl_t;

  // row pitch of a surface of width w
  function automatic logic [ROW_W-1:0] pitch_bytes(input logic [15:0] w, input logic [7:0] es,
                                                   input logic comp);
    logic [16:0] wq;
    logic [15:0] a;
    logic [24:0] pr;
    logic [24:0] pu;
    wq = ({1'b0, w} + 17'd3) >> 2;
    a  = comp ? wq[15:0] : w;
    pr = 25'(a) * 25'(es);
    pu = (pr + 25'd7) >> 3;
    return comp ? pr[ROW_W-1:0] : pu[ROW_W-1:0];
  endfunction

endpackage

// ===== rtl/mcta_ifs.sv =====
// mcta_ifs: valid/ready channel interfaces for texel requests and results.
// Depends on nothing.
interface mcta_req_if;
  logic        valid;
  logic        ready;
  logic [15:0] pixel_x;
  logic [15:0] pixel_y;
  logic [3:0]  mip_index;
  logic [10:0] layer_index;
  logic        plane_index;
  modport source (output valid, pixel_x, pixel_y, mip_index, layer_index, plane_index,
                  input ready);
  modport sink (input valid, pixel_x, pixel_y, mip_index, layer_index, plane_index,
                output ready);
endinterface

interface mcta_res_if;
  logic        valid;
  logic        ready;
  logic [48:0] byte_offset;
  logic [19:0] surface_row_bytes;
  logic [35:0] surface_bytes;
  logic [1:0]  status;
  modport source (output valid, byte_offset, surface_row_bytes, surface_bytes, status,
                  input ready);
  modport sink (input valid, byte_offset, surface_row_bytes, surface_bytes, status,
                output ready);
endinterface

// ===== rtl/mcta_cell.sv =====
// mcta_cell: one mip level of the chain; sizes its surface, adds it to the running
// sums and hands the halved surface to the next cell. Depends on mcta_pkg.
module mcta_cell
  import mcta_pkg::*;
#(
  parameter int IDX = 0
) (
  input  logic      clk,
  input  logic      rst_n,
  input  cell_ctl_t ctl,
  input  logic      in_vld,
  input  chain_t    in_d,
  output logic      out_vld,
  output chain_t    out_d
);

  localparam logic [MIP_W-1:0] CELL_IDX = MIP_W'(IDX);

  logic             out_vld_r;
  chain_t           out_d_r;
  chain_t           d_nxt;
  logic [16:0]      hq;
  logic [15:0]      hh;
  logic [TOT_W-1:0] t;
  logic [15:0]      w_half;
  logic [15:0]      h_half;

  always_comb begin
    hq     = ({1'b0, in_d.h} + 17'd3) >> 2;
    hh     = ctl.comp ? hq[15:0] : in_d.h;
    t      = TOT_W'(hh) * TOT_W'(in_d.row);
    w_half = (in_d.w >> 1 == 16'd0) ? 16'd1 : in_d.w >> 1;
    h_half = (in_d.h >> 1 == 16'd0) ? 16'd1 : in_d.h >> 1;
    d_nxt  = in_d;
    d_nxt.w   = w_half;
    d_nxt.h   = h_half;
    d_nxt.row = pitch_bytes(w_half, ctl.es, ctl.comp);
    if (CELL_IDX < ctl.mips) begin
      d_nxt.layer_bytes = in_d.layer_bytes + {1'b0, t};
    end
    if (CELL_IDX < {1'b0, ctl.mip}) begin
      d_nxt.prefix = in_d.prefix + {1'b0, t};
    end
    if (CELL_IDX == {1'b0, ctl.mip}) begin
      d_nxt.sel_row   = in_d.row;
      d_nxt.sel_total = t;
      d_nxt.sel_h     = in_d.h;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (in_vld) begin
      out_d_r <= d_nxt;
    end
  end

  assign out_vld = out_vld_r;
  assign out_d   = out_d_r;

endmodule

// ===== rtl/mcta_div.sv =====
// mcta_div: radix-4 restoring divider, row pitch over bytes per pixel, two quotient
// bits a cycle. Depends on mcta_pkg.
module mcta_div
  import mcta_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [ROW_W-1:0] dividend,
  input  logic [PIX_W-1:0] divisor,
  output logic             done,
  output logic [ROW_W-1:0] quotient
);

  localparam int STEPS = ROW_W / 2;
  localparam int CNT_W = $clog2(STEPS);

  logic             busy_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [ROW_W-1:0] dvd_r;
  logic [PIX_W-1:0] rem_r;
  logic [PIX_W-1:0] dsr_r;
  logic [PIX_W:0]   r1;
  logic [PIX_W:0]   r1s;
  logic [PIX_W:0]   r2;
  logic [PIX_W:0]   r2s;
  logic             q1;
  logic             q2;

  always_comb begin
    r1  = {rem_r, dvd_r[ROW_W-1]};
    q1  = r1 >= {1'b0, dsr_r};
    r1s = q1 ? r1 - {1'b0, dsr_r} : r1;
    r2  = {r1s[PIX_W-1:0], dvd_r[ROW_W-2]};
    q2  = r2 >= {1'b0, dsr_r};
    r2s = q2 ? r2 - {1'b0, dsr_r} : r2;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dividend;
      rem_r <= '0;
      dsr_r <= divisor;
    end else if (busy_r) begin
      dvd_r <= {dvd_r[ROW_W-3:0], q1, q2};
      rem_r <= r2s[PIX_W-1:0];
    end
  end

  assign done     = done_r;
  // zero bytes per pixel gives a zero limit
  assign quotient = (dsr_r == '0) ? '0 : dvd_r;

endmodule

// ===== rtl/mip_chain_texel_address_core.sv =====
// mip_chain_texel_address_core: top level; configuration registers, request
// control, the cell chain, the clamp divider and the offset arithmetic.
// Depends on mcta_pkg, mcta_ifs, mcta_cell and mcta_div.

// One request is in flight at a time. The request transfer seeds the chain; the request
// then passes through the row of mip cells (one level each), the two-bit-a-cycle divider
// that forms the x clamp limit (load, eleven steps, done flag), and the final multiplies
// and the output load. The next request can transfer only once the result is loaded into
// the output register; a result still waiting in the output register holds the finished
// request in its last phase until the register frees up.
// Configuration writes must only happen while no request is in flight.
module mip_chain_texel_address_core
  import mcta_pkg::*;
#(
  parameter int MAX_MIPS   = 16,
  parameter int MAX_LAYERS = 2048
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [2:0]        cfg_idx,
  input  logic [15:0]       cfg_wdata,
  mcta_req_if.sink          in_req,
  mcta_res_if.source        out_res
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CHAIN = 3'd1;
  localparam logic [2:0] S_DIV   = 3'd2;
  localparam logic [2:0] S_FIN1  = 3'd3;
  localparam logic [2:0] S_FIN2  = 3'd4;

  // configuration
  logic [15:0] base_width_r;
  logic [15:0] base_height_r;
  logic [4:0]  mip_count_r;
  logic [11:0] layer_count_r;
  logic [1:0]  plane_count_r;
  logic [7:0]  element_size_r;
  logic        block_comp_r;

  logic [2:0]  state_r;
  logic [15:0] px_r;
  logic [15:0] py_r;
  logic [3:0]  mip_r;
  logic        bad_r;
  logic [16:0] idx_r;
  logic        seed_vld_r;
  chain_t      seed_r;

  logic [MIP_W-1:0] mips;
  logic [15:0]      layers;
  logic [1:0]       planes;
  logic [15:0]      w0;
  logic [15:0]      h0;
  logic             accept;
  logic             bad_nxt;
  logic [16:0]      idx_nxt;
  logic [PIX_W-1:0] pix;
  cell_ctl_t        ctl;

  logic             vld_c [NUM_CELLS+1];
  chain_t           dat_c [NUM_CELLS+1];
  chain_t           fin;

  logic [36:0]      p0_r;
  logic [35:0]      p1_r;
  logic [BASE_W-1:0] base_r;

  logic             div_start;
  logic             div_done;
  logic [ROW_W-1:0] quo;
  logic [ROW_W-1:0] lx;
  logic [15:0]      ly;
  logic [15:0]      px_c;
  logic [15:0]      py_c;
  logic [TOT_W-1:0] m1_r;
  logic [ROW_W-1:0] m2_r;
  logic [BASE_W-1:0] sum;
  logic [BASE_W-1:0] off;

  logic              out_vld_r;
  logic [OFF_W-1:0]  out_off_r;
  logic [SROW_W-1:0] out_row_r;
  logic [SIZE_W-1:0] out_size_r;
  logic [1:0]        out_st_r;
  logic              out_load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_width_r   <= 16'd1;
      base_height_r  <= 16'd1;
      mip_count_r    <= 5'd1;
      layer_count_r  <= 12'd1;
      plane_count_r  <= 2'd1;
      element_size_r <= 8'd32;
      block_comp_r   <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_BASE_WIDTH:  base_width_r   <= cfg_wdata;
        REG_BASE_HEIGHT: base_height_r  <= cfg_wdata;
        REG_MIP_COUNT:   mip_count_r    <= cfg_wdata[4:0];
        REG_LAYER_COUNT: layer_count_r  <= cfg_wdata[11:0];
        REG_PLANE_COUNT: plane_count_r  <= cfg_wdata[1:0];
        REG_ELEM_SIZE:   element_size_r <= cfg_wdata[7:0];
        REG_BLOCK_COMP:  block_comp_r   <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    mips = (mip_count_r == 5'd0) ? 5'd1 : mip_count_r;
    if (mips > MIP_W'(MAX_MIPS)) begin
      mips = MIP_W'(MAX_MIPS);
    end
    layers = (layer_count_r == 12'd0) ? 16'd1 : {4'b0, layer_count_r};
    if (layers > 16'(MAX_LAYERS)) begin
      layers = 16'(MAX_LAYERS);
    end
    planes  = (plane_count_r == 2'd0) ? 2'd1 : plane_count_r;
    w0      = (base_width_r == 16'd0) ? 16'd1 : base_width_r;
    h0      = (base_height_r == 16'd0) ? 16'd1 : base_height_r;
    bad_nxt = ({1'b0, in_req.mip_index} >= mips) || ({5'b0, in_req.layer_index} >= layers)
              || ({1'b0, in_req.plane_index} >= planes);
    idx_nxt = in_req.plane_index ? {1'b0, layers} + {6'b0, in_req.layer_index}
                                 : {6'b0, in_req.layer_index};
    pix     = PIX_W'(({1'b0, element_size_r} + 9'd7) >> 3);
  end

  assign in_req.ready = (state_r == S_IDLE);
  assign accept       = in_req.valid && in_req.ready;
  assign div_start    = (state_r == S_CHAIN) && vld_c[NUM_CELLS];
  assign out_load     = (state_r == S_FIN2) && (!out_vld_r || out_res.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      seed_vld_r <= 1'b0;
    end else begin
      seed_vld_r <= accept;
      case (state_r)
        S_IDLE:  if (accept) state_r <= S_CHAIN;
        S_CHAIN: if (vld_c[NUM_CELLS]) state_r <= S_DIV;
        S_DIV:   if (div_done) state_r <= S_FIN1;
        S_FIN1:  state_r <= S_FIN2;
        S_FIN2:  if (out_load) state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      px_r   <= in_req.pixel_x;
      py_r   <= in_req.pixel_y;
      mip_r  <= in_req.mip_index;
      bad_r  <= bad_nxt;
      idx_r  <= idx_nxt;
      seed_r <= '{w: w0, h: h0, row: pitch_bytes(w0, element_size_r, block_comp_r),
                  layer_bytes: '0, prefix: '0, sel_row: '0, sel_total: '0, sel_h: 16'd1};
    end
  end

  assign ctl = '{mips: mips, mip: mip_r, es: element_size_r, comp: block_comp_r};

  assign vld_c[0] = seed_vld_r;
  assign dat_c[0] = seed_r;

  for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
    mcta_cell #(.IDX(i)) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .ctl     (ctl),
      .in_vld  (vld_c[i]),
      .in_d    (dat_c[i]),
      .out_vld (vld_c[i+1]),
      .out_d   (dat_c[i+1])
    );
  end

  assign fin = dat_c[NUM_CELLS];

  // layer start split into two partial products; settles while the divider runs
  always_ff @(posedge clk) begin
    p0_r   <= 37'(idx_r) * 37'(fin.layer_bytes[19:0]);
    p1_r   <= 36'(idx_r) * 36'(fin.layer_bytes[ACC_W-1:20]);
    base_r <= {2'b0, p1_r, 20'b0} + BASE_W'(p0_r) + BASE_W'(fin.prefix);
  end

  mcta_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (fin.sel_row),
    .divisor  (pix),
    .done     (div_done),
    .quotient (quo)
  );

  always_comb begin
    lx   = (quo == '0) ? '0 : quo - 1'b1;
    ly   = (fin.sel_row == '0) ? 16'd0 : fin.sel_h - 16'd1;
    px_c = ({6'b0, px_r} > lx) ? lx[15:0] : px_r;
    py_c = (py_r > ly) ? ly : py_r;
  end

  always_ff @(posedge clk) begin
    if (state_r == S_FIN1) begin
      m1_r <= TOT_W'(py_c) * TOT_W'(fin.sel_row);
      m2_r <= ROW_W'(px_c) * ROW_W'(pix);
    end
  end

  always_comb begin
    sum = base_r + BASE_W'(m1_r) + BASE_W'(m2_r);
    if (bad_r) begin
      off = '0;
    end else if (block_comp_r) begin
      off = base_r;
    end else begin
      off = sum;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (out_load) begin
      out_vld_r <= 1'b1;
    end else if (out_res.ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_off_r  <= (|off[BASE_W-1:OFF_W]) ? '1 : off[OFF_W-1:0];
      out_row_r  <= (|fin.sel_row[ROW_W-1:SROW_W]) ? '1 : fin.sel_row[SROW_W-1:0];
      out_size_r <= (|fin.sel_total[TOT_W-1:SIZE_W]) ? '1 : fin.sel_total[SIZE_W-1:0];
      if (bad_r) begin
        out_st_r <= ST_RANGE;
      end else if (block_comp_r) begin
        out_st_r <= ST_COMPRESSED;
      end else begin
        out_st_r <= ST_OK;
      end
    end
  end

  assign out_res.valid             = out_vld_r;
  assign out_res.byte_offset       = out_off_r;
  assign out_res.surface_row_bytes = out_row_r;
  assign out_res.surface_bytes     = out_size_r;
  assign out_res.status            = out_st_r;

`ifndef SYNTHESIS
  a_range_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_res.valid && out_res.status == ST_RANGE |-> out_res.byte_offset == '0)
    else $error("range error result with nonzero offset");
  a_accept_chain: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> state_r == S_CHAIN)
    else $error("request transfer did not start the chain");
  a_div_state: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> state_r == S_DIV)
    else $error("divider finished outside divide phase");
  a_chain_end: assert property (@(posedge clk) disable iff (!rst_n)
    vld_c[NUM_CELLS] |-> state_r == S_CHAIN)
    else $error("chain token left outside chain phase");
`endif

endmodule

// ===== tb/mip_chain_texel_address_core_test.sv =====
// mip_chain_texel_address_core_test: self-checking bench for the texel address core.
// Depends on mcta_pkg, mcta_ifs and the core; predicts every result and compares it.
module mip_chain_texel_address_core_test;
  import mcta_pkg::*;

  typedef struct packed {
    logic [15:0] px;
    logic [15:0] py;
    logic [3:0]  mip;
    logic [10:0] layer;
    logic        plane;
  } texel_req_t;

  typedef struct packed {
    logic [48:0] offset;
    logic [19:0] row;
    logic [35:0] total;
    logic [1:0]  status;
  } texel_res_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [2:0] cfg_idx;
  logic [15:0] cfg_wdata;

  mcta_req_if req_ch();
  mcta_res_if res_ch();

  mip_chain_texel_address_core u_top (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata),
    .in_req(req_ch.sink), .out_res(res_ch.source)
  );

  // shadow of the register file
  logic [15:0] sh_width, sh_height;
  logic [4:0]  sh_mips;
  logic [11:0] sh_layers;
  logic [1:0]  sh_planes;
  logic [7:0]  sh_es;
  logic        sh_comp;

  texel_req_t pending_reqs[$];
  texel_res_t expected_res[$];
  int send_idle_pct, recv_idle_pct;
  int failures;
  int quiet_cycles;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic longint unsigned nz(longint unsigned v);
    return (v == 0) ? 1 : v;
  endfunction

  function automatic longint unsigned clip(longint unsigned v, longint unsigned top);
    return (v > top) ? top : v;
  endfunction

  function automatic texel_res_t predict_texel(texel_req_t r);
    longint unsigned mips, layers, planes, w, h, es, lbytes, prefix, row, total;
    longint unsigned rr, tt, off, pix, lx, ly, px, py;
    bit bad;
    texel_res_t res;
    es = 64'(sh_es);
    mips = clip(nz(64'(sh_mips)), 16);
    layers = clip(nz(64'(sh_layers)), 2048);
    planes = nz(64'(sh_planes));
    w = nz(64'(sh_width));
    h = nz(64'(sh_height));
    lbytes = 0; prefix = 0; row = 0; total = 0;
    bad = (r.mip >= mips) || (r.layer >= layers) || (r.plane >= planes);
    for (int m = 0; m < 16; m++) begin
      if (sh_comp) begin
        rr = ((w + 3) / 4) * es;
        tt = ((h + 3) / 4) * rr;
      end else begin
        rr = (w * es + 7) / 8;
        tt = h * rr;
      end
      if (m < mips) lbytes += tt;
      if (m < r.mip) prefix += tt;
      if (m == r.mip) begin
        row = rr;
        total = tt;
      end
      w = nz(w >> 1);
      h = nz(h >> 1);
    end
    off = (r.plane * layers + r.layer) * lbytes + prefix;
    if (bad) begin
      res.status = ST_RANGE;
      off = 0;
    end else if (sh_comp) begin
      res.status = ST_COMPRESSED;
    end else begin
      pix = (es + 7) / 8;
      lx = pix ? row / pix : 0;
      ly = row ? total / row : 0;
      if (lx) lx--;
      if (ly) ly--;
      px = (r.px > lx) ? lx : r.px;
      py = (r.py > ly) ? ly : r.py;
      off += py * row + px * pix;
      res.status = ST_OK;
    end
    res.offset = 49'(clip(off, (64'd1 << 49) - 1));
    res.row = 20'(clip(row, (64'd1 << 20) - 1));
    res.total = 36'(clip(total, (64'd1 << 36) - 1));
    return res;
  endfunction

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      req_ch.valid <= 1'b0;
    end else if (!req_ch.valid || req_ch.ready) begin
      if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        texel_req_t r;
        r = pending_reqs.pop_front();
        expected_res.push_back(predict_texel(r));
        req_ch.valid <= 1'b1;
        {req_ch.pixel_x, req_ch.pixel_y, req_ch.mip_index, req_ch.layer_index,
         req_ch.plane_index} <= r;
      end else begin
        req_ch.valid <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      res_ch.ready <= 1'b0;
    end else begin
      if (res_ch.valid && res_ch.ready) begin
        if (expected_res.size() == 0) begin
          $error("result transfer with nothing expected");
          failures++;
        end else begin
          texel_res_t e;
          e = expected_res.pop_front();
          if (res_ch.byte_offset !== e.offset) begin
            $error("byte_offset expected %0d actual %0d", e.offset, res_ch.byte_offset);
            failures++;
          end
          if (res_ch.surface_row_bytes !== e.row) begin
            $error("surface_row_bytes expected %0d actual %0d", e.row,
                   res_ch.surface_row_bytes);
            failures++;
          end
          if (res_ch.surface_bytes !== e.total) begin
            $error("surface_bytes expected %0d actual %0d", e.total, res_ch.surface_bytes);
            failures++;
          end
          if (res_ch.status !== e.status) begin
            $error("status expected %0d actual %0d", e.status, res_ch.status);
            failures++;
          end
        end
      end
      res_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready) || !rst_n) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > 20000) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_BASE_WIDTH:  sh_width = val;
      REG_BASE_HEIGHT: sh_height = val;
      REG_MIP_COUNT:   sh_mips = val[4:0];
      REG_LAYER_COUNT: sh_layers = val[11:0];
      REG_PLANE_COUNT: sh_planes = val[1:0];
      REG_ELEM_SIZE:   sh_es = val[7:0];
      REG_BLOCK_COMP:  sh_comp = val[0];
      default: ;
    endcase
  endtask

  task automatic set_config(input logic [15:0] w, input logic [15:0] h, input logic [4:0] mc,
                            input logic [11:0] lc, input logic [1:0] pc, input logic [7:0] es,
                            input logic comp);
    write_reg(REG_BASE_WIDTH, w);
    write_reg(REG_BASE_HEIGHT, h);
    write_reg(REG_MIP_COUNT, {11'd0, mc});
    write_reg(REG_LAYER_COUNT, {4'd0, lc});
    write_reg(REG_PLANE_COUNT, {14'd0, pc});
    write_reg(REG_ELEM_SIZE, {8'd0, es});
    write_reg(REG_BLOCK_COMP, {15'd0, comp});
  endtask

  // let the queue drain and every expected result arrive, then let the bench idle
  task automatic drain;
    while (pending_reqs.size() != 0 || req_ch.valid || expected_res.size() != 0)
      @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  function automatic texel_req_t rand_req(bit in_range);
    texel_req_t r;
    r.px = $urandom_range(3) == 0 ? 16'hFFFF : 16'($urandom_range(sh_width + 2));
    r.py = $urandom_range(3) == 0 ? 16'($urandom) : 16'($urandom_range(sh_height + 2));
    if (in_range) begin
      r.mip = 4'($urandom_range(32'(clip(nz(64'(sh_mips)), 16) - 1)));
      r.layer = 11'($urandom_range(32'(clip(nz(64'(sh_layers)), 2048) - 1)));
      r.plane = 1'($urandom_range(32'(nz(64'(sh_planes)) - 1)));
    end else begin
      r.mip = 4'($urandom);
      r.layer = 11'($urandom);
      r.plane = 1'($urandom);
    end
    return r;
  endfunction

  task automatic random_config;
    logic [15:0] w, h;
    int k;
    k = $urandom_range(9);
    w = (k == 0) ? 16'hFFFF : (k < 7 ? 16'($urandom_range(1, 300)) : 16'($urandom));
    h = (k == 0) ? 16'hFFFF : (k < 7 ? 16'($urandom_range(1, 300)) : 16'($urandom));
    set_config(w, h, 5'($urandom_range(31)), ($urandom_range(4) == 0) ? 12'($urandom) :
               12'($urandom_range(8)), 2'($urandom), 8'($urandom),
               $urandom_range(3) == 0);
  endtask

  initial begin
    texel_req_t r;
    failures = 0;
    send_idle_pct = 38;
    recv_idle_pct = 80;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = REG_BASE_WIDTH;
    cfg_wdata = 16'd0;
    sh_width = 1; sh_height = 1; sh_mips = 1; sh_layers = 1; sh_planes = 1;
    sh_es = 32; sh_comp = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // reset values first
    pending_reqs.push_back('{16'd0, 16'd0, 4'd0, 11'd0, 1'b0});
    pending_reqs.push_back('{16'hFFFF, 16'hFFFF, 4'd15, 11'h7FF, 1'b1});
    drain();
    // largest surface, saturation of all outputs
    set_config(16'hFFFF, 16'hFFFF, 5'd31, 12'hFFF, 2'd3, 8'hFF, 1'b0);
    pending_reqs.push_back('{16'hFFFF, 16'hFFFF, 4'd0, 11'd2047, 1'b1});
    pending_reqs.push_back('{16'hFFFF, 16'hFFFF, 4'd15, 11'd2047, 1'b1});
    pending_reqs.push_back('{16'd5, 16'd7, 4'd3, 11'd0, 1'b0});
    drain();
    // zero counts and zero element size
    set_config(16'd0, 16'd0, 5'd0, 12'd0, 2'd0, 8'd0, 1'b0);
    pending_reqs.push_back('{16'd9, 16'd9, 4'd0, 11'd0, 1'b0});
    pending_reqs.push_back('{16'd0, 16'd0, 4'd1, 11'd0, 1'b0});
    pending_reqs.push_back('{16'd0, 16'd0, 4'd0, 11'd1, 1'b0});
    pending_reqs.push_back('{16'd0, 16'd0, 4'd0, 11'd0, 1'b1});
    drain();
    // odd bit counts, sub-byte pixels
    set_config(16'd37, 16'd19, 5'd6, 12'd3, 2'd2, 8'd3, 1'b0);
    pending_reqs.push_back('{16'd36, 16'd18, 4'd0, 11'd2, 1'b1});
    pending_reqs.push_back('{16'hFFFF, 16'd1, 4'd5, 11'd1, 1'b0});
    pending_reqs.push_back('{16'd2, 16'd2, 4'd9, 11'd1, 1'b0});
    drain();
    set_config(16'd37, 16'd19, 5'd6, 12'd3, 2'd2, 8'd12, 1'b0);
    pending_reqs.push_back('{16'd40, 16'd3, 4'd2, 11'd0, 1'b1});
    drain();
    // compressed, and index error winning over it
    set_config(16'd130, 16'd66, 5'd8, 12'd4, 2'd2, 8'd16, 1'b1);
    pending_reqs.push_back('{16'd1, 16'd1, 4'd3, 11'd3, 1'b1});
    pending_reqs.push_back('{16'd1, 16'd1, 4'd8, 11'd0, 1'b0});
    pending_reqs.push_back('{16'd1, 16'd1, 4'd0, 11'd4, 1'b0});
    drain();

    for (int phase = 0; phase < 3; phase++) begin
      if (phase == 1) begin
        send_idle_pct = 80;
        recv_idle_pct = 38;
      end else if (phase == 2) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      for (int cfgs = 0; cfgs < 10; cfgs++) begin
        random_config();
        for (int i = 0; i < 33; i++) begin
          r = rand_req($urandom_range(9) < 8);
          pending_reqs.push_back(r);
        end
        drain();
      end
    end
    if (failures == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
